FILE: hdl/quaternion_rigid_point_transform_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion rigid point transform.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_RIGID_POINT_TRANSFORM_DEFINES_SVH
`define QUATERNION_RIGID_POINT_TRANSFORM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRPT_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define QRPT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/qrpt_pkg.sv
// ---------------------------------------------------------------------------
// qrpt_pkg
// Shared widths, register indices, the matrix unit state type and the
// matrix bundle passed from the matrix unit to the point pipeline.
// ---------------------------------------------------------------------------
package qrpt_pkg;

    localparam int QUAT_W   = 16;
    localparam int COORD_W  = 32;
    localparam int ENTRY_W  = 32;
    localparam int FRAC_W   = 30;
    localparam int N_ENTRY  = 9;
    localparam int PROD_W   = ENTRY_W + COORD_W;
    localparam int SUM_W    = 36;
    localparam int NUM_W    = 34;
    localparam int NORM_W   = 33;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int ADDR_W   = 5;

    localparam logic [2:0] REG_QUAT_0  = 3'd0;
    localparam logic [2:0] REG_QUAT_1  = 3'd1;
    localparam logic [2:0] REG_QUAT_2  = 3'd2;
    localparam logic [2:0] REG_QUAT_3  = 3'd3;
    localparam logic [2:0] REG_SHIFT_X = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y = 3'd5;
    localparam logic [2:0] REG_SHIFT_Z = 3'd6;
    localparam logic [2:0] REG_MIRROR  = 3'd7;

    typedef enum logic [1:0] {
        M_PROD,
        M_SUM,
        M_DIV,
        M_DONE
    } mstate_t;

    typedef struct packed {
        logic                             ready;
        logic                             degenerate;
        logic [N_ENTRY-1:0][ENTRY_W-1:0]  entry;
    } matrix_t;

endpackage

FILE: hdl/quaternion_rigid_point_transform.sv
// ---------------------------------------------------------------------------
// quaternion_rigid_point_transform
// Rotates each Q16.16 point by the quaternion matrix and adds the shift.
// ---------------------------------------------------------------------------
// One point is taken every cycle and moves through the three-stage pipeline;
// a stall at the output holds the whole pipeline. After reset,
// and after every write to a quaternion register or to the mirror
// register, the matrix unit rebuilds the nine entries with its single
// shared divider at one quotient bit per cycle, during which s_tready
// stays low. A zero quaternion skips the division and gives degenerate
// results.
module quaternion_rigid_point_transform
    import qrpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*COORD_W-1:0]  s_tdata,  // point_x, point_y, point_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*COORD_W-1:0]  m_tdata,  // moved_x, moved_y, moved_z
    output logic                  m_tuser   // degenerate
);

    logic signed [QUAT_W-1:0]  quat_0_reg, quat_1_reg, quat_2_reg, quat_3_reg;
    logic signed [COORD_W-1:0] shift_x_reg, shift_y_reg, shift_z_reg;
    logic                      mirror_reg;

    logic       wr;
    logic [2:0] idx;
    logic       rebuild;
    matrix_t    mx;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign idx     = paddr[ADDR_W-1:2];
    assign rebuild = wr && (idx != REG_SHIFT_X) && (idx != REG_SHIFT_Y)
                        && (idx != REG_SHIFT_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_0_reg  <= 16'sh7fff;
            quat_1_reg  <= '0;
            quat_2_reg  <= '0;
            quat_3_reg  <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
            mirror_reg  <= 1'b0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_QUAT_0:  quat_0_reg  <= pwdata[QUAT_W-1:0];
                REG_QUAT_1:  quat_1_reg  <= pwdata[QUAT_W-1:0];
                REG_QUAT_2:  quat_2_reg  <= pwdata[QUAT_W-1:0];
                REG_QUAT_3:  quat_3_reg  <= pwdata[QUAT_W-1:0];
                REG_SHIFT_X: shift_x_reg <= pwdata;
                REG_SHIFT_Y: shift_y_reg <= pwdata;
                REG_SHIFT_Z: shift_z_reg <= pwdata;
                REG_MIRROR:  mirror_reg  <= pwdata[0];
                default:     mirror_reg  <= mirror_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_QUAT_0:  prdata = 32'(quat_0_reg);
            REG_QUAT_1:  prdata = 32'(quat_1_reg);
            REG_QUAT_2:  prdata = 32'(quat_2_reg);
            REG_QUAT_3:  prdata = 32'(quat_3_reg);
            REG_SHIFT_X: prdata = shift_x_reg;
            REG_SHIFT_Y: prdata = shift_y_reg;
            REG_SHIFT_Z: prdata = shift_z_reg;
            REG_MIRROR:  prdata = {31'd0, mirror_reg};
            default:     prdata = '0;
        endcase
    end

    qrpt_matrix u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rebuild),
        .quat_0 (quat_0_reg),
        .quat_1 (quat_1_reg),
        .quat_2 (quat_2_reg),
        .quat_3 (quat_3_reg),
        .mirror (mirror_reg),
        .mx     (mx)
    );

    qrpt_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .mx        (mx),
        .shift_x   (shift_x_reg),
        .shift_y   (shift_y_reg),
        .shift_z   (shift_z_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_deg   (m_tuser)
    );

endmodule

FILE: hdl/qrpt_matrix.sv
// ---------------------------------------------------------------------------
// qrpt_matrix
// Builds the nine rotation entries from the quaternion with one shared
// restoring divider that produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
module qrpt_matrix
    import qrpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [QUAT_W-1:0] quat_0,
    input  logic signed [QUAT_W-1:0] quat_1,
    input  logic signed [QUAT_W-1:0] quat_2,
    input  logic signed [QUAT_W-1:0] quat_3,
    input  logic                     mirror,
    output matrix_t                  mx
);

    mstate_t state_reg, state_next;

    logic signed [31:0] p00_reg, p11_reg, p22_reg, p33_reg;
    logic signed [31:0] p01_reg, p02_reg, p03_reg, p12_reg, p13_reg, p23_reg;
    logic signed [NUM_W-1:0] num_reg [N_ENTRY];
    logic [NORM_W-1:0] norm_reg;
    logic              deg_reg;
    logic [3:0]        idx_reg;
    logic [4:0]        step_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [N_ENTRY-1:0][ENTRY_W-1:0] entry_reg;

    logic [NORM_W-1:0] norm_next;
    logic signed [NUM_W-1:0] num_cur;
    logic              neg;
    logic [NUM_W-1:0]  mag;
    logic [NUM_W-1:0]  cur;
    logic              qbit;
    logic [NUM_W-1:0]  rem_next;
    logic [QUO_W-1:0]  quo_next;
    logic [ENTRY_W-1:0] quo_ext;
    logic              last_step;
    logic              last_entry;

    function automatic logic signed [NUM_W-1:0] ext(input logic signed [31:0] v);
        ext = NUM_W'(v);
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_PROD: state_next = M_SUM;
            M_SUM:  state_next = (norm_next == '0) ? M_DONE : M_DIV;
            M_DIV:  state_next = (last_step && last_entry) ? M_DONE : M_DIV;
            M_DONE: state_next = M_DONE;
            default: state_next = M_PROD;
        endcase
        if (start)
        begin
            state_next = M_PROD;
        end
    end

    // Outputs.
    always_comb
    begin
        mx.ready      = (state_reg == M_DONE);
        mx.degenerate = deg_reg;
        mx.entry      = entry_reg;
    end

    always_comb
    begin
        norm_next = NORM_W'(p00_reg) + NORM_W'(p11_reg) + NORM_W'(p22_reg)
                  + NORM_W'(p33_reg);
        num_cur   = num_reg[idx_reg];
        neg       = num_cur[NUM_W-1];
        mag       = neg ? NUM_W'(-num_cur) : NUM_W'(num_cur);
        // The integer bit is found without a shift, as the magnitude never
        // exceeds the norm.
        cur       = (step_reg == '0) ? mag : {rem_reg[NUM_W-2:0], 1'b0};
        qbit      = (cur >= {1'b0, norm_reg});
        rem_next  = qbit ? (cur - {1'b0, norm_reg}) : cur;
        quo_next  = {quo_reg[QUO_W-2:0], qbit};
        quo_ext   = {1'b0, quo_next};
        last_step = (step_reg == 5'(FRAC_W));
        last_entry = (idx_reg == 4'(N_ENTRY - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_PROD;
            idx_reg   <= '0;
            step_reg  <= '0;
            deg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == M_SUM)
            begin
                deg_reg  <= (norm_next == '0);
                idx_reg  <= '0;
                step_reg <= '0;
            end
            else if (state_reg == M_DIV)
            begin
                if (last_step)
                begin
                    step_reg <= '0;
                    idx_reg  <= idx_reg + 4'd1;
                end
                else
                begin
                    step_reg <= step_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_PROD)
        begin
            p00_reg <= quat_0 * quat_0;
            p11_reg <= quat_1 * quat_1;
            p22_reg <= quat_2 * quat_2;
            p33_reg <= quat_3 * quat_3;
            p01_reg <= quat_0 * quat_1;
            p02_reg <= quat_0 * quat_2;
            p03_reg <= quat_0 * quat_3;
            p12_reg <= quat_1 * quat_2;
            p13_reg <= quat_1 * quat_3;
            p23_reg <= quat_2 * quat_3;
        end
        if (state_reg == M_SUM)
        begin
            norm_reg   <= norm_next;
            num_reg[0] <= ext(p00_reg) + ext(p11_reg) - ext(p22_reg) - ext(p33_reg);
            num_reg[1] <= (ext(p12_reg) + ext(p03_reg)) <<< 1;
            num_reg[2] <= (ext(p13_reg) - ext(p02_reg)) <<< 1;
            num_reg[3] <= (ext(p12_reg) - ext(p03_reg)) <<< 1;
            num_reg[4] <= ext(p00_reg) - ext(p11_reg) + ext(p22_reg) - ext(p33_reg);
            num_reg[5] <= (ext(p23_reg) + ext(p01_reg)) <<< 1;
            num_reg[6] <= (ext(p13_reg) + ext(p02_reg)) <<< 1;
            num_reg[7] <= (ext(p23_reg) - ext(p01_reg)) <<< 1;
            num_reg[8] <= ext(p00_reg) - ext(p11_reg) - ext(p22_reg) + ext(p33_reg);
        end
        if (state_reg == M_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (last_step)
            begin
                entry_reg[idx_reg] <= (neg ^ mirror) ? -quo_ext : quo_ext;
            end
        end
    end

endmodule

FILE: hdl/qrpt_pipe.sv
// ---------------------------------------------------------------------------
// qrpt_pipe
// Three-stage point pipeline: products, floored sums with the shift, and
// saturation, or zeros for a degenerate matrix, into the output register.
// ---------------------------------------------------------------------------
module qrpt_pipe
    import qrpt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  matrix_t                   mx,
    input  logic signed [COORD_W-1:0] shift_x,
    input  logic signed [COORD_W-1:0] shift_y,
    input  logic signed [COORD_W-1:0] shift_z,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [3*COORD_W-1:0]      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [3*COORD_W-1:0]      out_data,
    output logic                      out_deg
);

    logic                      v1_reg, v2_reg, v3_reg;
    logic signed [PROD_W-1:0]  prod_reg [N_ENTRY];
    logic                      deg1_reg, deg2_reg, deg3_reg;
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic [3*COORD_W-1:0]      data_reg;

    logic                      advance;
    logic signed [COORD_W-1:0] pt [3];
    logic signed [COORD_W-1:0] sh [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    logic [3*COORD_W-1:0]      data_next;

    // The whole pipeline moves together; a stalled output freezes it.
    assign advance  = !v3_reg || out_ready;
    assign in_ready = advance && mx.ready;

    assign out_valid = v3_reg;
    assign out_data  = data_reg;
    assign out_deg   = deg3_reg;

    always_comb
    begin
        pt[0] = in_data[COORD_W-1:0];
        pt[1] = in_data[2*COORD_W-1:COORD_W];
        pt[2] = in_data[3*COORD_W-1:2*COORD_W];
        sh[0] = shift_x;
        sh[1] = shift_y;
        sh[2] = shift_z;
        for (int r = 0; r < 3; r++)
        begin
            // An arithmetic right shift floors toward minus infinity.
            sum_next[r] = SUM_W'(prod_reg[3*r]   >>> FRAC_W)
                        + SUM_W'(prod_reg[3*r+1] >>> FRAC_W)
                        + SUM_W'(prod_reg[3*r+2] >>> FRAC_W)
                        + SUM_W'(sh[r]);
        end
        for (int r = 0; r < 3; r++)
        begin
            if (deg2_reg)
            begin
                data_next[r*COORD_W +: COORD_W] = '0;
            end
            else if (sum_reg[r] > SUM_W'(32'sh7fff_ffff))
            begin
                data_next[r*COORD_W +: COORD_W] = 32'h7fff_ffff;
            end
            else if (sum_reg[r] < -SUM_W'(36'sh0_8000_0000))
            begin
                data_next[r*COORD_W +: COORD_W] = 32'h8000_0000;
            end
            else
            begin
                data_next[r*COORD_W +: COORD_W] = sum_reg[r][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid && mx.ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < N_ENTRY; i++)
            begin
                prod_reg[i] <= $signed(mx.entry[i]) * pt[i % 3];
            end
            deg1_reg <= mx.degenerate;
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= sum_next[r];
            end
            deg2_reg <= deg1_reg;
            data_reg <= data_next;
            deg3_reg <= deg2_reg;
        end
    end

endmodule

FILE: hdl/qrpt_checker.sv
// ---------------------------------------------------------------------------
// qrpt_checker
// Port-level checks on the quaternion rigid point transform.
// ---------------------------------------------------------------------------
`include "quaternion_rigid_point_transform_defines.svh"

module qrpt_checker
    import qrpt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [3*COORD_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A result request that is held back keeps its payload.
    `QRPT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A degenerate result carries zero coordinates.
    `QRPT_ASSERT_SAME(a_deg_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0)

    // A stalled output freezes the pipeline, so no new request is taken.
    `QRPT_ASSERT_SAME(a_stall_in, clk, rst_n, m_tvalid && !m_tready, !s_tready)

endmodule

bind quaternion_rigid_point_transform qrpt_checker u_qrpt_checker (.*);
